/* design/assert_macros.svh */
// Assertion macros used by the checker file rldm_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* design/rldm_pkg.sv */
// Package for the radial lens distortion map: payload types, formats, register indexes.
// No dependencies.
package rldm_pkg;
	localparam int CoordW = 20;
	localparam int DiffW = 21;
	localparam int RadW = 21;
	localparam int SqW = 42;
	localparam int CoefW = 32;
	localparam int MaxOrder = 5;
	localparam int RadiusShift = 11;
	localparam int HornShift = 8 + RadiusShift;
	localparam int RootSteps = RadW;
	localparam int RootPerStage = 3;
	localparam int RootStages = RootSteps / RootPerStage;

	localparam logic [2:0] RegCenterX = 3'd0;
	localparam logic [2:0] RegCenterY = 3'd1;
	localparam logic [2:0] RegCoeff0 = 3'd2;
	localparam logic [2:0] RegCoeff1 = 3'd3;
	localparam logic [2:0] RegCoeff2 = 3'd4;
	localparam logic [2:0] RegCoeff3 = 3'd5;
	localparam logic [2:0] RegCoeff4 = 3'd6;
	localparam logic [2:0] RegCoeff5 = 3'd7;

	typedef struct packed {
		logic signed [CoordW-1:0] in_x;
		logic signed [CoordW-1:0] in_y;
	} in_item_t;

	typedef struct packed {
		logic signed [CoordW-1:0] out_x;
		logic signed [CoordW-1:0] out_y;
		logic clipped;
	} out_item_t;

	typedef struct packed {
		logic signed [CoordW-1:0] center_x;
		logic signed [CoordW-1:0] center_y;
		logic signed [MaxOrder:0][CoefW-1:0] coeff;
	} cfg_t;

	// data carried alongside the root and Horner stages
	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [DiffW-1:0] dx;
		logic signed [DiffW-1:0] dy;
	} point_t;

	function automatic logic signed [CoefW-1:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi) return CoefW'(hi);
		if (v < lo) return CoefW'(lo);
		return CoefW'(v);
	endfunction
endpackage

/* design/rldm_root.sv */
// Pipelined integer square root of dx^2+dy^2, three result bits per stage.
// Depends on rldm_pkg.
module rldm_root (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input rldm_pkg::point_t pt,
	output logic valid_out,
	output rldm_pkg::point_t pt_out,
	output logic [rldm_pkg::RadW-1:0] radius
);
	import rldm_pkg::*;

	logic [RootStages:0] vld_s1;
	point_t pt_s1 [RootStages+1];
	logic [SqW+1:0] rem_s1 [RootStages+1];
	logic [RadW-1:0] res_s1 [RootStages+1];
	logic signed [2*DiffW-1:0] sqx;
	logic signed [2*DiffW-1:0] sqy;

	assign sqx = pt.dx * pt.dx;
	assign sqy = pt.dy * pt.dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1[0] <= 1'b0;
		else vld_s1[0] <= valid;
	end
	always_ff @(posedge clk) begin
		pt_s1[0] <= pt;
		rem_s1[0] <= (SqW+2)'(unsigned'(sqx)) + (SqW+2)'(unsigned'(sqy));
		res_s1[0] <= '0;
	end

	// digit-by-digit root: each step decides one result bit from the top
	for (genvar s = 0; s < RootStages; s++) begin : g_st
		logic [SqW+1:0] rem_n;
		logic [RadW-1:0] res_n;
		always_comb begin
			logic [SqW+1:0] trial;
			int b;
			rem_n = rem_s1[s];
			res_n = res_s1[s];
			for (int k = 0; k < RootPerStage; k++) begin
				b = RootSteps - 1 - (s * RootPerStage + k);
				trial = ((SqW+2)'(res_n) << (b + 1)) | ((SqW+2)'(1) << (2 * b));
				if (rem_n >= trial) begin
					rem_n = rem_n - trial;
					res_n = res_n | (RadW'(1) << b);
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s1[s+1] <= 1'b0;
			else vld_s1[s+1] <= vld_s1[s];
		end
		always_ff @(posedge clk) begin
			pt_s1[s+1] <= pt_s1[s];
			rem_s1[s+1] <= rem_n;
			res_s1[s+1] <= res_n;
		end
	end

	assign valid_out = vld_s1[RootStages];
	assign pt_out = pt_s1[RootStages];
	assign radius = res_s1[RootStages];
endmodule

/* design/rldm_horner.sv */
// Horner evaluation of the scale polynomial, multiply and add in separate stages.
// Depends on rldm_pkg.
module rldm_horner (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input rldm_pkg::point_t pt,
	input logic [rldm_pkg::RadW-1:0] radius,
	input rldm_pkg::cfg_t cfg,
	output logic valid_out,
	output rldm_pkg::point_t pt_out,
	output logic zero_out,
	output logic signed [rldm_pkg::CoefW-1:0] scale
);
	import rldm_pkg::*;

	localparam int NS = MaxOrder;

	logic [NS:0] vld_s2;
	point_t pt_s2 [NS+1];
	logic [RadW-1:0] rad_s2 [NS+1];
	logic signed [CoefW-1:0] f_s2 [NS+1];
	logic [NS-1:0] vldm_s3;
	point_t ptm_s3 [NS];
	logic [RadW-1:0] radm_s3 [NS];
	logic signed [CoefW+RadW:0] prod_s3 [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2[0] <= 1'b0;
		else vld_s2[0] <= valid;
	end
	always_ff @(posedge clk) begin
		pt_s2[0] <= pt;
		rad_s2[0] <= radius;
		f_s2[0] <= signed'(cfg.coeff[MaxOrder]);
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		logic signed [65:0] acc;
		// multiply stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vldm_s3[i] <= 1'b0;
			else vldm_s3[i] <= vld_s2[i];
		end
		always_ff @(posedge clk) begin
			ptm_s3[i] <= pt_s2[i];
			radm_s3[i] <= rad_s2[i];
			prod_s3[i] <= f_s2[i] * signed'({1'b0, rad_s2[i]});
		end
		// floor shift, saturate, add next coefficient, saturate
		always_comb begin
			acc = 66'(sat32(66'(prod_s3[i] >>> HornShift)));
			acc = acc + 66'(signed'(cfg.coeff[MaxOrder-1-i]));
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s2[i+1] <= 1'b0;
			else vld_s2[i+1] <= vldm_s3[i];
		end
		always_ff @(posedge clk) begin
			pt_s2[i+1] <= ptm_s3[i];
			rad_s2[i+1] <= radm_s3[i];
			f_s2[i+1] <= sat32(acc);
		end
	end

	assign valid_out = vld_s2[NS];
	assign pt_out = pt_s2[NS];
	assign zero_out = (rad_s2[NS] == '0);
	assign scale = f_s2[NS];
endmodule

/* design/rldm_apply.sv */
// Scales offset, rounds, adds centre back, saturates; radius 0 keeps the input.
// Depends on rldm_pkg.
module rldm_apply (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input rldm_pkg::point_t pt,
	input logic zero,
	input logic signed [rldm_pkg::CoefW-1:0] scale,
	input rldm_pkg::cfg_t cfg,
	output logic done,
	output rldm_pkg::out_item_t result
);
	import rldm_pkg::*;

	localparam int PW = CoefW + DiffW;

	logic vld_s1;
	logic zero_s1;
	point_t pt_s1;
	logic signed [PW-1:0] px_s1;
	logic signed [PW-1:0] py_s1;
	logic signed [PW:0] sx;
	logic signed [PW:0] sy;
	logic signed [PW:0] cmax;
	logic signed [PW:0] cmin;
	logic signed [PW:0] half;
	logic cx_hi, cx_lo, cy_hi, cy_lo;
	logic vld_q;
	out_item_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= valid;
	end
	always_ff @(posedge clk) begin
		zero_s1 <= zero;
		pt_s1 <= pt;
		px_s1 <= scale * pt.dx;
		py_s1 <= scale * pt.dy;
	end

	// round half up from Q.24 to integer
	assign half = (PW+1)'(1) <<< 23;
	assign sx = (PW+1)'(signed'(cfg.center_x))
		+ ((PW+1)'(px_s1) + half >>> 24);
	assign sy = (PW+1)'(signed'(cfg.center_y))
		+ ((PW+1)'(py_s1) + half >>> 24);
	assign cmax = (PW+1)'(524287);
	assign cmin = -(PW+1)'(524288);
	assign cx_hi = sx > cmax;
	assign cx_lo = sx < cmin;
	assign cy_hi = sy > cmax;
	assign cy_lo = sy < cmin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (zero_s1) begin
			res_q.out_x <= pt_s1.x;
			res_q.out_y <= pt_s1.y;
			res_q.clipped <= 1'b0;
		end else begin
			res_q.out_x <= cx_hi ? CoordW'(cmax) : cx_lo ? CoordW'(cmin) : CoordW'(sx);
			res_q.out_y <= cy_hi ? CoordW'(cmax) : cy_lo ? CoordW'(cmin) : CoordW'(sy);
			res_q.clipped <= cx_hi | cx_lo | cy_hi | cy_lo;
		end
	end

	assign done = vld_q;
	assign result = res_q;
endmodule

/* design/radial_lens_distortion_map.sv */
// Top level of the radial lens distortion map: registers, input stage, datapath chain.
// Depends on rldm_pkg, rldm_root, rldm_horner, rldm_apply.
// Takes one point per clock whenever start is high (busy is always low) and gives its
// result on done after 1 input stage, 1 squaring stage and 7 root stages (three bits
// of the 21-bit square root each), 1 + 2*5 Horner stages (multiply then add per order),
// 1 multiply and 1 output stage. Results cannot be held off, so the pipeline never
// stalls. Write registers only while idle.
module radial_lens_distortion_map (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input rldm_pkg::in_item_t in_item,
	output logic done,
	output rldm_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	import rldm_pkg::*;

	cfg_t cfg_q;
	logic vld_s1;
	point_t pt_s1;
	point_t pt_in;
	logic rv;
	point_t rpt;
	logic [RadW-1:0] rad;
	logic hv;
	point_t hpt;
	logic hz;
	logic signed [CoefW-1:0] hf;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= '0;
			cfg_q.center_y <= '0;
			cfg_q.coeff <= {{MaxOrder{32'd0}}, 32'd16777216};
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegCenterX: cfg_q.center_x <= cfg_data[CoordW-1:0];
				RegCenterY: cfg_q.center_y <= cfg_data[CoordW-1:0];
				default: cfg_q.coeff[cfg_index - RegCoeff0] <= cfg_data;
			endcase
		end
	end

	always_comb begin
		pt_in.x = in_item.in_x;
		pt_in.y = in_item.in_y;
		pt_in.dx = DiffW'(in_item.in_x) - DiffW'(cfg_q.center_x);
		pt_in.dy = DiffW'(in_item.in_y) - DiffW'(cfg_q.center_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start && !busy;
	end
	always_ff @(posedge clk) pt_s1 <= pt_in;

	rldm_root u_root (.clk(clk), .arst_n(arst_n), .valid(vld_s1), .pt(pt_s1),
		.valid_out(rv), .pt_out(rpt), .radius(rad));

	rldm_horner u_horner (.clk(clk), .arst_n(arst_n), .valid(rv), .pt(rpt), .radius(rad),
		.cfg(cfg_q), .valid_out(hv), .pt_out(hpt), .zero_out(hz), .scale(hf));

	rldm_apply u_apply (.clk(clk), .arst_n(arst_n), .valid(hv), .pt(hpt), .zero(hz),
		.scale(hf), .cfg(cfg_q), .done(done), .result(out_item));
endmodule

/* design/rldm_checker.sv */
// Port-level checker for the radial lens distortion map, bound to the top level.
// Depends on rldm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rldm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rldm_pkg::out_item_t out_item
);
	import rldm_pkg::*;

	localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
	localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

	`CHK_IMPLY(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")
	`CHK_IMPLY(a_done_has_start, clk, arst_n, done, $past(start && !busy, 22),
		"result without a transfer 22 cycles before")
	`CHK_IMPLY(a_start_gives_done, clk, arst_n, $past(start && !busy, 22) && $past(arst_n, 22),
		done, "transfer lost")
	`CHK_IMPLY(a_clip_flag, clk, arst_n, done && out_item.clipped,
		out_item.out_x == CoordMax || out_item.out_x == CoordMin || out_item.out_y == CoordMax || out_item.out_y == CoordMin,
		"clip flag without a saturated coordinate")
endmodule

bind radial_lens_distortion_map rldm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done), .out_item(out_item));
